// File: src/sdrc_pkg.sv
// ----------------------------------------------------------------------------
// Stereo compressor package
// Shared types, constants and the saturation helper used by the compressor.
// ----------------------------------------------------------------------------
package sdrc_pkg;

    localparam int SMP_W    = 24;
    localparam int CFG_IDXW = 3;
    localparam int CFG_DW   = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDXW-1:0] REG_IN_GAIN  = 3'd0;
    localparam logic [CFG_IDXW-1:0] REG_OUT_GAIN = 3'd1;
    localparam logic [CFG_IDXW-1:0] REG_THRESH   = 3'd2;
    localparam logic [CFG_IDXW-1:0] REG_EXPONENT = 3'd3;
    localparam logic [CFG_IDXW-1:0] REG_ATTACK   = 3'd4;
    localparam logic [CFG_IDXW-1:0] REG_RELEASE  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_IN_GAIN  = 16'd4096;
    localparam logic [15:0] RST_OUT_GAIN = 16'd4096;
    localparam logic [15:0] RST_THRESH   = 16'd61870;
    localparam logic [15:0] RST_EXPONENT = 16'd0;
    localparam logic [23:0] RST_ATTACK   = 24'd16761121;
    localparam logic [23:0] RST_RELEASE  = 24'd16773997;

    // Number of root table entries, one per fraction bit of the exponent.
    localparam int ROOT_N = 16;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_in;
        logic signed [SMP_W-1:0] right_in;
        logic                    block_end;
    } t_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_out;
        logic signed [SMP_W-1:0] right_out;
        logic                    left_reducing;
        logic                    right_reducing;
        logic                    block_end_out;
    } t_out;

    typedef struct packed {
        logic [15:0] in_gain;
        logic [15:0] out_gain;
        logic [15:0] threshold_level;
        logic [15:0] curve_exponent;
        logic [23:0] attack_coef;
        logic [23:0] release_coef;
    } t_cfg;

    // Clamp a gain product magnitude to what a signed 24-bit value can hold.
    function automatic logic [23:0] sat_mag(input logic neg, input logic [27:0] mg);
        if (neg) begin
            if (mg > 28'd8388608) return 24'h800000;
            else return mg[23:0];
        end else begin
            if (mg > 28'd8388607) return 24'h7FFFFF;
            else return mg[23:0];
        end
    endfunction

endpackage

// File: src/sdrc_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// One 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module sdrc_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // Product is registered and available in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: src/sdrc_core.sv
// ----------------------------------------------------------------------------
// Compressor sequencer
// Walks both channels of a frame through gain, log2, exp2, envelope,
// reduction and output gain on the shared multiplier.
// ----------------------------------------------------------------------------
module sdrc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sdrc_pkg::t_cfg i_cfg,
    input  logic           i_start,
    input  sdrc_pkg::t_in  i_frame,
    input  logic           i_take,
    output logic           o_ready,
    output logic           o_done,
    output sdrc_pkg::t_out o_result
);

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_GAINM = 5'd2;
    localparam logic [4:0] S_GAINR = 5'd3;
    localparam logic [4:0] S_LNORM = 5'd4;
    localparam logic [4:0] S_LSQM  = 5'd5;
    localparam logic [4:0] S_LSQR  = 5'd6;
    localparam logic [4:0] S_EXPM  = 5'd7;
    localparam logic [4:0] S_EXPR  = 5'd8;
    localparam logic [4:0] S_POW   = 5'd9;
    localparam logic [4:0] S_POWM  = 5'd10;
    localparam logic [4:0] S_POWR  = 5'd11;
    localparam logic [4:0] S_TGTM  = 5'd12;
    localparam logic [4:0] S_TGTR  = 5'd13;
    localparam logic [4:0] S_ENVM  = 5'd14;
    localparam logic [4:0] S_ENVR  = 5'd15;
    localparam logic [4:0] S_REDM  = 5'd16;
    localparam logic [4:0] S_REDR  = 5'd17;
    localparam logic [4:0] S_DIV   = 5'd18;
    localparam logic [4:0] S_OUTM  = 5'd19;
    localparam logic [4:0] S_OUTR  = 5'd20;
    localparam logic [4:0] S_DONE  = 5'd21;

    logic [4:0]  r_state;
    logic        r_ch;
    logic [4:0]  r_cnt;
    logic [3:0]  r_idx;
    logic [63:0] r_sx, r_sr, r_sbit;
    logic [30:0] r_stab [sdrc_pkg::ROOT_N];
    logic [23:0] r_env [2];
    sdrc_pkg::t_in r_frame;
    logic        r_neg;
    logic [23:0] r_v;
    logic [30:0] r_y;
    logic [4:0]  r_m;
    logic [15:0] r_frac;
    logic        r_sel;
    logic [20:0] r_lv;
    logic [21:0] r_d;
    logic [7:0]  r_n;
    logic [15:0] r_f;
    logic [30:0] r_r;
    logic [23:0] r_tgt;
    logic        r_red;
    logic [23:0] r_rem, r_q;
    logic [23:0] r_res [2];
    logic [1:0]  r_redf;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    logic [19:0] thr;
    logic [23:0] smp, smp_mag, env_cur, coef, diff, xm, gmag, step, env_new;
    logic        rising;
    logic [21:0] dmag;
    logic [63:0] sq_t, sq_x, sq_r;
    logic        sq_ge;
    logic [31:0] lsq;
    logic [15:0] lfrac;
    logic [20:0] lval;
    logic [22:0] pm, pval;
    logic [8:0]  sh;
    logic [50:0] tsh;
    logic [24:0] rem2;
    logic        dge;

    sdrc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Working values derived from the current state registers.
    always_comb begin
        thr     = {(i_cfg.threshold_level == 16'd0) ? 16'd1 : i_cfg.threshold_level, 4'b0};
        smp     = r_ch ? r_frame.right_in : r_frame.left_in;
        smp_mag = smp[23] ? (~smp + 24'd1) : smp;
        env_cur = r_env[r_ch];
        rising  = r_tgt > env_cur;
        coef    = rising ? i_cfg.attack_coef : i_cfg.release_coef;
        diff    = rising ? (r_tgt - env_cur) : (env_cur - r_tgt);
        xm      = r_red ? r_q : r_v;
        dmag    = r_d[21] ? (~r_d + 22'd1) : r_d;
        // The input gain saturates by the sample's sign, the output gain by the
        // sign kept from the input stage.
        gmag    = sdrc_pkg::sat_mag((r_state == S_GAINR) ? smp[23] : r_neg, prod[39:12]);
        step    = prod[47:24];
        env_new = rising ? (r_tgt - step) : (r_tgt + step);
        // One step of the bit-serial square root used to build the root table.
        sq_t    = r_sr + r_sbit;
        sq_ge   = r_sx >= sq_t;
        sq_x    = sq_ge ? (r_sx - sq_t) : r_sx;
        sq_r    = sq_ge ? ((r_sr >> 1) + r_sbit) : (r_sr >> 1);
        // One squaring step of log2.
        lsq     = prod[61:30];
        lfrac   = {r_frac[14:0], lsq[31]};
        lval    = {r_m, lfrac};
        // Exponent product floored to 16 fraction bits.
        pm      = r_d[21] ? 23'((prod[37:0] + 38'd65535) >> 16) : 23'(prod[37:0] >> 16);
        pval    = r_d[21] ? (~pm + 23'd1) : pm;
        sh      = 9'sd30 - {r_n[7], r_n};
        tsh     = prod[50:0] >> sh[5:0];
        // One restoring division step.
        rem2    = {r_rem, r_q[23]};
        dge     = rem2 >= {1'b0, env_cur};
    end

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_GAINM: begin
                mul_a = {8'b0, smp_mag};
                mul_b = {16'b0, i_cfg.in_gain};
            end
            S_LSQM: begin
                mul_a = {1'b0, r_y};
                mul_b = {1'b0, r_y};
            end
            S_EXPM: begin
                mul_a = {16'b0, i_cfg.curve_exponent};
                mul_b = {10'b0, dmag};
            end
            S_POWM: begin
                mul_a = {1'b0, r_r};
                mul_b = {1'b0, r_stab[r_cnt[3:0]]};
            end
            S_TGTM: begin
                mul_a = {12'b0, thr};
                mul_b = {1'b0, r_r};
            end
            S_ENVM: begin
                mul_a = {8'b0, coef};
                mul_b = {8'b0, diff};
            end
            S_REDM: begin
                mul_a = {8'b0, r_v};
                mul_b = {12'b0, thr};
            end
            S_OUTM: begin
                mul_a = {8'b0, xm};
                mul_b = {16'b0, i_cfg.out_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ch     <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_sx     <= 64'd2 << 60;
            r_sr     <= '0;
            r_sbit   <= 64'd1 << 62;
            r_env[0] <= '0;
            r_env[1] <= '0;
        end else begin
            case (r_state)
                S_INIT: begin
                    r_sx   <= sq_x;
                    r_sr   <= sq_r;
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_stab[r_idx] <= sq_r[30:0];
                        r_sx   <= sq_r << 30;
                        r_sr   <= '0;
                        r_sbit <= 64'd1 << 62;
                        r_idx  <= r_idx + 4'd1;
                        if (r_idx == 4'(sdrc_pkg::ROOT_N - 1)) r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_frame <= i_frame;
                        r_ch    <= 1'b0;
                        r_state <= S_GAINM;
                    end
                end
                S_GAINM: r_state <= S_GAINR;
                S_GAINR: begin
                    r_neg <= smp[23];
                    r_v   <= gmag;
                    if (i_cfg.curve_exponent == 16'd0) begin
                        r_tgt   <= {4'b0, thr};
                        r_state <= S_ENVM;
                    end else if (gmag == 24'd0) begin
                        r_tgt   <= '0;
                        r_state <= S_ENVM;
                    end else begin
                        r_y     <= {gmag, 7'b0};
                        r_m     <= 5'd23;
                        r_sel   <= 1'b0;
                        r_state <= S_LNORM;
                    end
                end
                S_LNORM: begin
                    if (r_y[30]) begin
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= S_LSQM;
                    end else begin
                        r_y <= r_y << 1;
                        r_m <= r_m - 5'd1;
                    end
                end
                S_LSQM: r_state <= S_LSQR;
                S_LSQR: begin
                    r_frac <= lfrac;
                    r_y    <= lsq[31] ? lsq[31:1] : lsq[30:0];
                    r_cnt  <= r_cnt + 5'd1;
                    r_state <= S_LSQM;
                    if (r_cnt == 5'd15) begin
                        if (!r_sel) begin
                            r_lv    <= lval;
                            r_y     <= {4'b0, thr, 7'b0};
                            r_m     <= 5'd23;
                            r_sel   <= 1'b1;
                            r_state <= S_LNORM;
                        end else begin
                            r_d     <= {1'b0, r_lv} - {1'b0, lval};
                            r_state <= S_EXPM;
                        end
                    end
                end
                S_EXPM: r_state <= S_EXPR;
                S_EXPR: begin
                    r_n     <= {pval[22], pval[22:16]};
                    r_f     <= pval[15:0];
                    r_r     <= 31'd1 << 30;
                    r_cnt   <= '0;
                    r_state <= S_POW;
                end
                S_POW: begin
                    if (r_f[~r_cnt[3:0]]) begin
                        r_state <= S_POWM;
                    end else if (r_cnt == 5'd15) begin
                        r_state <= S_TGTM;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_POWM: r_state <= S_POWR;
                S_POWR: begin
                    r_r <= prod[60:30];
                    if (r_cnt == 5'd15) begin
                        r_state <= S_TGTM;
                    end else begin
                        r_cnt   <= r_cnt + 5'd1;
                        r_state <= S_POW;
                    end
                end
                S_TGTM: r_state <= S_TGTR;
                S_TGTR: begin
                    if (sh[8]) r_tgt <= 24'hFFFFFF;
                    else if (sh > 9'd63) r_tgt <= '0;
                    else if (tsh > 51'hFFFFFF) r_tgt <= 24'hFFFFFF;
                    else r_tgt <= tsh[23:0];
                    r_state <= S_ENVM;
                end
                S_ENVM: r_state <= S_ENVR;
                S_ENVR: begin
                    r_env[r_ch] <= env_new;
                    r_red       <= env_new > {4'b0, thr};
                    r_state     <= (env_new > {4'b0, thr}) ? S_REDM : S_OUTM;
                end
                S_REDM: r_state <= S_REDR;
                S_REDR: begin
                    r_rem   <= {4'b0, prod[43:24]};
                    r_q     <= prod[23:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= dge ? 24'(rem2 - {1'b0, env_cur}) : rem2[23:0];
                    r_q   <= {r_q[22:0], dge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd23) r_state <= S_OUTM;
                end
                S_OUTM: r_state <= S_OUTR;
                S_OUTR: begin
                    r_res[r_ch]  <= r_neg ? (~gmag + 24'd1) : gmag;
                    r_redf[r_ch] <= r_red;
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= S_GAINM;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_take) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_result.left_out       = r_res[0];
    assign o_result.right_out      = r_res[1];
    assign o_result.left_reducing  = r_redf[0];
    assign o_result.right_reducing = r_redf[1];
    assign o_result.block_end_out  = r_frame.block_end;

    // The normalizer is only entered with a nonzero value.
    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LNORM |-> r_y != '0)
        else $error("log2 normalizer entered with zero");

    // Squaring always starts from a normalized mantissa.
    a_sq_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LSQM |-> r_y[30])
        else $error("log2 mantissa not normalized");

    // The partial remainder stays below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < env_cur)
        else $error("division remainder out of range");

    // A started frame makes the sequencer busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && o_ready |=> !o_ready)
        else $error("sequencer still ready after a start");

endmodule

// File: src/stereo_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// Stereo dynamic range compressor
// Feed-forward compressor for one stereo frame per transaction.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_in_data  (t_in)
//   out      output     o_out_valid / i_out_stall  o_out_data (t_out)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A frame's run is set by the shared multiplier and the bit-serial normalizer
// and divider that work both channels in turn; the next frame is taken only
// after the result has moved to the output register.
// After reset the root table is built; no frame is taken then.
// Reset is synchronous and active low; it clears the envelopes and state.
// The output register holds a result under stall while the next frame runs.
// ----------------------------------------------------------------------------
module stereo_dynamic_range_compressor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sdrc_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sdrc_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sdrc_pkg::CFG_IDXW-1:0]       i_cfg_index,
    input  logic [sdrc_pkg::CFG_DW-1:0]         i_cfg_data
);

    sdrc_pkg::t_cfg r_cfg;
    logic           r_out_valid;
    sdrc_pkg::t_out r_out_data;

    logic           core_ready, core_done, take, start;
    sdrc_pkg::t_out core_res;

    assign start = i_in_valid && core_ready;
    assign take  = core_done && (!r_out_valid || !i_out_stall);

    sdrc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (start),
        .i_frame  (i_in_data),
        .i_take   (take),
        .o_ready  (core_ready),
        .o_done   (core_done),
        .o_result (core_res)
    );

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_gain         <= sdrc_pkg::RST_IN_GAIN;
            r_cfg.out_gain        <= sdrc_pkg::RST_OUT_GAIN;
            r_cfg.threshold_level <= sdrc_pkg::RST_THRESH;
            r_cfg.curve_exponent  <= sdrc_pkg::RST_EXPONENT;
            r_cfg.attack_coef     <= sdrc_pkg::RST_ATTACK;
            r_cfg.release_coef    <= sdrc_pkg::RST_RELEASE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sdrc_pkg::REG_IN_GAIN:  r_cfg.in_gain         <= i_cfg_data[15:0];
                sdrc_pkg::REG_OUT_GAIN: r_cfg.out_gain        <= i_cfg_data[15:0];
                sdrc_pkg::REG_THRESH:   r_cfg.threshold_level <= i_cfg_data[15:0];
                sdrc_pkg::REG_EXPONENT: r_cfg.curve_exponent  <= i_cfg_data[15:0];
                sdrc_pkg::REG_ATTACK:   r_cfg.attack_coef     <= i_cfg_data;
                sdrc_pkg::REG_RELEASE:  r_cfg.release_coef    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= core_res;
        end
    end

    assign o_in_stall  = !core_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// File: verif/tb_stereo_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// Stereo compressor testbench
// Drives stereo frames and register writes into the compressor, predicts each
// compressed frame with a bit-exact fixed-point model and compares the results
// field by field. Both sides idle and stall in random bursts, bar the last phase.
// ----------------------------------------------------------------------------
module tb_stereo_dynamic_range_compressor;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1900;
    localparam int DRAIN_CYCLES   = 400;

    // An index beyond the register list; writes to it are ignored.
    localparam logic [sdrc_pkg::CFG_IDXW-1:0] REG_UNUSED = 3'd7;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    sdrc_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_stall = 1'b0;
    sdrc_pkg::t_out out_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [sdrc_pkg::CFG_IDXW-1:0] cfg_index;
    logic [sdrc_pkg::CFG_DW-1:0]   cfg_data;

    stereo_dynamic_range_compressor i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Clock with a period of 20 time units.
    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state: registers and the per-channel envelopes.
    sdrc_pkg::t_cfg shadow_cfg;
    logic [23:0]    env_level [2];
    sdrc_pkg::t_out frame_queue [$];
    int             error_count;
    int             idle_cycles = 0;
    bit             stall_enable;

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Sign-magnitude gain in Q4.12, truncated, saturated to 24 bits.
    function automatic longint scale_gain(input longint x, input logic [15:0] g);
        longint unsigned m;
        longint r;
        m = (x < 0) ? -x : x;
        r = longint'((m * g) >> 12);
        if (x < 0) r = -r;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // log2 with 16 fraction bits by repeated squaring.
    function automatic longint log2_fixed(input logic [31:0] u);
        int m;
        longint unsigned y;
        longint fr;
        m = 0;
        fr = 0;
        while (m < 31 && (u >> (m + 1)) != 0) m++;
        y = longint'(u) << (30 - m);
        for (int k = 0; k < 16; k++) begin
            y = (y * y) >> 30;
            fr <<= 1;
            if (y >= (64'd2 << 30)) begin
                y >>= 1;
                fr |= 1;
            end
        end
        return longint'(m) * 65536 + fr;
    endfunction

    function automatic longint floor_q16(input longint a);
        if (a >= 0) return a / 65536;
        return -((-a + 65535) / 65536);
    endfunction

    // base * 2^(p/65536), truncated and clamped to 24 bits unsigned.
    function automatic logic [23:0] pow2_scale(input logic [31:0] base, input longint p);
        longint n;
        logic [31:0] f;
        longint unsigned r, s, t;
        int sh;
        n = floor_q16(p);
        f = 32'(p - n * 65536);
        r = 64'd1 << 30;
        s = int_sqrt(64'd2 << 60);
        for (int k = 1; k <= 16; k++) begin
            if ((f >> (16 - k)) & 1) r = (r * s) >> 30;
            s = int_sqrt(s << 30);
        end
        t = longint'(base) * r;
        sh = 30 - int'(n);
        if (sh < 0) return 24'hFFFFFF;
        if (sh > 63) return 24'd0;
        t >>= sh;
        return (t > 64'hFFFFFF) ? 24'hFFFFFF : t[23:0];
    endfunction

    // Compute one compressed frame and advance the envelopes.
    function automatic sdrc_pkg::t_out compress_frame(input sdrc_pkg::t_in fr);
        sdrc_pkg::t_out res;
        logic [31:0] thr, v, tgt, env;
        longint x, d, m;
        logic red;
        logic signed [23:0] smp;
        thr = ((shadow_cfg.threshold_level == 0) ? 32'd1
               : 32'(shadow_cfg.threshold_level)) << 4;
        for (int c = 0; c < 2; c++) begin
            smp = (c == 0) ? fr.left_in : fr.right_in;
            x = scale_gain(longint'(smp), shadow_cfg.in_gain);
            v = 32'((x < 0) ? -x : x);
            env = 32'(env_level[c]);
            if (shadow_cfg.curve_exponent == 0) tgt = thr;
            else if (v == 0) tgt = 0;
            else begin
                d = log2_fixed(v) - log2_fixed(thr);
                tgt = 32'(pow2_scale(thr,
                          floor_q16(longint'(shadow_cfg.curve_exponent) * d)));
            end
            if (tgt > env)
                env = tgt - 32'((longint'(shadow_cfg.attack_coef) * (tgt - env)) >> 24);
            else
                env = tgt + 32'((longint'(shadow_cfg.release_coef) * (env - tgt)) >> 24);
            env &= 32'hFFFFFF;
            env_level[c] = env[23:0];
            red = env > thr;
            if (red) begin
                m = longint'((longint'(v) * thr) / env);
                x = (x < 0) ? -m : m;
            end
            x = scale_gain(x, shadow_cfg.out_gain);
            if (c == 0) begin
                res.left_out = 24'(x);
                res.left_reducing = red;
            end else begin
                res.right_out = 24'(x);
                res.right_reducing = red;
            end
        end
        res.block_end_out = fr.block_end;
        return res;
    endfunction

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(int'($urandom_range(0, 4000)) - 2000);
            3: return 24'd0;
            default: return 24'($urandom);
        endcase
    endfunction

    // Random idle bursts on the sending side.
    task automatic sender_gap();
        if (stall_enable && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Valid stays high after a transaction until the next frame replaces the
    // payload, or an idle burst or a drain drops it.
    task automatic send_frame(input sdrc_pkg::t_in fr);
        sender_gap();
        in_valid <= 1'b1;
        in_data  <= fr;
        do @(posedge clk); while (in_stall);
        frame_queue.push_back(compress_frame(fr));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (frame_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [sdrc_pkg::CFG_IDXW-1:0] idx,
                             input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sdrc_pkg::REG_IN_GAIN:  shadow_cfg.in_gain         = val[15:0];
            sdrc_pkg::REG_OUT_GAIN: shadow_cfg.out_gain        = val[15:0];
            sdrc_pkg::REG_THRESH:   shadow_cfg.threshold_level = val[15:0];
            sdrc_pkg::REG_EXPONENT: shadow_cfg.curve_exponent  = val[15:0];
            sdrc_pkg::REG_ATTACK:   shadow_cfg.attack_coef     = val;
            sdrc_pkg::REG_RELEASE:  shadow_cfg.release_coef    = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [15:0] ig, input logic [15:0] og,
                             input logic [15:0] th, input logic [15:0] ex,
                             input logic [23:0] at, input logic [23:0] rl);
        write_reg(sdrc_pkg::REG_IN_GAIN, 24'(ig));
        write_reg(sdrc_pkg::REG_OUT_GAIN, 24'(og));
        write_reg(sdrc_pkg::REG_THRESH, 24'(th));
        write_reg(sdrc_pkg::REG_EXPONENT, 24'(ex));
        write_reg(sdrc_pkg::REG_ATTACK, at);
        write_reg(sdrc_pkg::REG_RELEASE, rl);
    endtask

    // Output side: random stall bursts and comparison against the predictor.
    always @(posedge clk) begin
        sdrc_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (frame_queue.size() == 0) begin
                report_mismatch("unexpected output transaction", out_data.left_out, 24'd0);
            end else begin
                want = frame_queue.pop_front();
                if (out_data.left_out !== want.left_out)
                    report_mismatch("left_out", out_data.left_out, want.left_out);
                if (out_data.right_out !== want.right_out)
                    report_mismatch("right_out", out_data.right_out, want.right_out);
                if (out_data.left_reducing !== want.left_reducing)
                    report_mismatch("left_reducing", 24'(out_data.left_reducing),
                                    24'(want.left_reducing));
                if (out_data.right_reducing !== want.right_reducing)
                    report_mismatch("right_reducing", 24'(out_data.right_reducing),
                                    24'(want.right_reducing));
                if (out_data.block_end_out !== want.block_end_out)
                    report_mismatch("block_end_out", 24'(out_data.block_end_out),
                                    24'(want.block_end_out));
            end
        end
        if (!stall_enable) out_stall <= 1'b0;
        else if (out_stall) out_stall <= ($urandom_range(0, 2) != 0);
        else out_stall <= ($urandom_range(0, 4) == 0);
    end

    // Watchdog: counts cycles in which no transaction is accepted.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_stereo_dynamic_range_compressor: FAIL");
            $finish;
        end
    end

    // Directed frames: left, right, block_end, expected result where obvious.
    typedef struct {
        logic [23:0]    l;
        logic [23:0]    r;
        logic           be;
        bit             typed;
        sdrc_pkg::t_out want;
    } t_row;

    t_row directed [12];

    initial begin
        sdrc_pkg::t_in fr;
        sdrc_pkg::t_out got;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        error_count = 0;
        stall_enable = 1'b1;
        shadow_cfg = '{sdrc_pkg::RST_IN_GAIN, sdrc_pkg::RST_OUT_GAIN,
                       sdrc_pkg::RST_THRESH, sdrc_pkg::RST_EXPONENT,
                       sdrc_pkg::RST_ATTACK, sdrc_pkg::RST_RELEASE};
        env_level[0] = 0;
        env_level[1] = 0;

        // Silence after reset passes unchanged, envelope still below threshold.
        directed[0] = '{24'd0, 24'd0, 1'b0, 1'b1, '{24'd0, 24'd0, 1'b0, 1'b0, 1'b0}};
        directed[1] = '{24'h7FFFFF, 24'h800000, 1'b1, 1'b0, '0};
        directed[2] = '{24'h800000, 24'h7FFFFF, 1'b0, 1'b0, '0};
        directed[3] = '{24'd1, 24'hFFFFFF, 1'b1, 1'b0, '0};
        directed[4] = '{24'h555555, 24'hAAAAAA, 1'b0, 1'b0, '0};
        directed[5] = '{24'hAAAAAA, 24'h555555, 1'b1, 1'b0, '0};
        directed[6] = '{24'd0, 24'h7FFFFF, 1'b0, 1'b0, '0};
        directed[7] = '{24'h7FFFFF, 24'd0, 1'b1, 1'b0, '0};
        directed[8] = '{24'h0F1DE0, 24'hF0E220, 1'b0, 1'b0, '0};
        directed[9] = '{24'd0, 24'd0, 1'b0, 1'b0, '0};
        directed[10] = '{24'h800000, 24'h800000, 1'b1, 1'b0, '0};
        directed[11] = '{24'd0, 24'd0, 1'b0, 1'b0, '0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, rows up to 5 at reset settings; typed rows checked against the table.
        foreach (directed[i]) begin
            fr = '{directed[i].l, directed[i].r, directed[i].be};
            if (directed[i].typed) begin
                got = compress_frame(fr);
                if (got !== directed[i].want)
                    report_mismatch($sformatf("table row %0d", i), got.left_out,
                                    directed[i].want.left_out);
                env_level[0] = 0;
                env_level[1] = 0;
            end
            send_frame(fr);
            if (i == 5) begin
                wait_drained();
                // Zero threshold register, full exponent, extreme gains.
                write_all(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 24'd0, 24'hFFFFFF);
                write_reg(REG_UNUSED, 24'h123456);
            end
        end
        wait_drained();

        // Random part in phases with varied settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(16'd4096, 16'd4096, 16'd1, 16'd32768, 24'd0, 24'd0);
                1: write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
                7: write_all(sdrc_pkg::RST_IN_GAIN, sdrc_pkg::RST_OUT_GAIN,
                             sdrc_pkg::RST_THRESH, 16'd43690,
                             sdrc_pkg::RST_ATTACK, sdrc_pkg::RST_RELEASE);
                default: write_all(16'($urandom), 16'($urandom_range(0, 16384)),
                                   16'($urandom_range(1, 65535)), 16'($urandom),
                                   24'($urandom), 24'($urandom));
            endcase
            if (ph == 7) stall_enable = 1'b0;
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                send_frame('{rand_sample(), rand_sample(), 1'($urandom)});
                if (ph == 3 && n == 100) wait_drained();
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("tb_stereo_dynamic_range_compressor: PASS");
        else
            $display("tb_stereo_dynamic_range_compressor: FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/sdrc_pkg.sv
src/sdrc_mul.sv
src/sdrc_core.sv
src/stereo_dynamic_range_compressor.sv
verif/tb_stereo_dynamic_range_compressor.sv
